>>> design/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types, codes and sizes of the priority thread scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

	localparam int MAX_SLOTS_DEF = 8;
	localparam int NO_PRIORITY   = 256;
	localparam int ID_SHIFT      = 16;

	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_SCHEDULE = 3'd1,
		OP_SLEEP    = 3'd2,
		OP_ADD      = 3'd3,
		OP_EVENT    = 3'd4,
		OP_KILL     = 3'd5,
		OP_BLOCK    = 3'd6,
		OP_NOP      = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_LAST     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_EMIT_EV,
		S_DONE,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  priority_req;
		logic [31:0] duration;
		logic [31:0] period;
		logic [31:0] thread_id;
		logic [2:0]  slot;
		logic        blocked_flag;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  status;
		logic [2:0]  event_index;
		logic [31:0] thread_id_out;
		logic [2:0]  current_slot_out;
		logic        switch_request;
		logic        last;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic start;     // latch item, reset walk index
		logic step;      // process one walk element
		logic finish;    // apply the op's closing update
		logic load_ev;   // load a fired event result
		logic load_st;   // load the status result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic walk_done;
		logic ev_fire;   // current step fires an event (tick)
	} sts_t;

endpackage

>>> design/pts_datapath.sv
// ----------------------------------------------------------------------------
// pts_datapath
// Thread table, event list and one-element-per-cycle walk unit that pauses while a fired event is emitted.
// ----------------------------------------------------------------------------
module pts_datapath #(
	parameter int MAX_SLOTS = pts_pkg::MAX_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pts_pkg::in_item_t  in_item,
	input  pts_pkg::cmd_t      cmd,
	output pts_pkg::sts_t      sts,
	output pts_pkg::out_item_t res
);
	import pts_pkg::*;

	localparam int SW = $clog2(MAX_SLOTS);
	localparam int CW = $clog2(MAX_SLOTS + 1);

	logic [MAX_SLOTS-1:0] alive_q, asleep_q, blocked_q;
	logic [7:0]  prio_q  [MAX_SLOTS];
	logic [31:0] wake_q  [MAX_SLOTS];
	logic [SW-1:0] nxt_q [MAX_SLOTS];
	logic [SW-1:0] prv_q [MAX_SLOTS];
	logic [31:0] id_q    [MAX_SLOTS];
	logic [31:0] eper_q  [MAX_SLOTS];
	logic [31:0] edue_q  [MAX_SLOTS];
	logic [SW-1:0] cur_q;
	logic [CW-1:0] tcnt_q, ecnt_q;
	logic [31:0] time_q;
	logic [15:0] idc_q;

	in_item_t      it_q;
	logic [CW-1:0] idx_q;     // walk counter
	logic [SW-1:0] p_q;       // ring pointer for schedule
	logic [8:0]    best_q;
	logic [SW-1:0] free_q, kill_q;
	logic          free_ok_q, kill_ok_q;
	logic [SW-1:0] fire_q;
	status_t       st_q;      // status of the closing update
	status_t       fin_st;
	out_item_t     st_item;

	logic [SW-1:0] iw;
	logic [31:0]   tnow;
	logic [SW-1:0] cur_ix;
	assign iw     = idx_q[SW-1:0];
	assign tnow   = time_q;   // time is advanced at start of a tick
	assign cur_ix = cur_q;

	// walk length and event firing test
	always_comb begin
		sts.ev_fire   = 1'b0;
		sts.walk_done = 1'b1;
		case (op_t'(it_q.op))
			OP_TICK: begin
				sts.walk_done = (idx_q >= CW'(MAX_SLOTS));
				sts.ev_fire = !sts.walk_done && (idx_q < ecnt_q) && (edue_q[iw] == tnow);
			end
			OP_SCHEDULE: sts.walk_done = (idx_q >= tcnt_q);
			OP_ADD, OP_KILL: sts.walk_done = (idx_q >= CW'(MAX_SLOTS));
			default: sts.walk_done = 1'b1;
		endcase
	end

	logic [31:0] cur_id;
	assign cur_id = alive_q[cur_ix] ? id_q[cur_ix] : 32'd0;

	// status decided before the counts move
	always_comb begin
		fin_st = ST_OK;
		case (op_t'(it_q.op))
			OP_ADD: if (!(free_ok_q && tcnt_q < CW'(MAX_SLOTS)))
				fin_st = ST_FULL;
			OP_EVENT: if (ecnt_q >= CW'(MAX_SLOTS))
				fin_st = ST_FULL;
			OP_KILL: if (tcnt_q == CW'(1))
				fin_st = ST_LAST;
			else if (!kill_ok_q)
				fin_st = ST_NOTFOUND;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q   <= '0;
			asleep_q  <= '0;
			blocked_q <= '0;
			cur_q     <= '0;
			tcnt_q    <= '0;
			ecnt_q    <= '0;
			time_q    <= '0;
			idc_q     <= '0;
		end else begin
			if (cmd.start && op_t'(in_item.op) == OP_TICK)
				time_q <= time_q + 32'd1;
			if (cmd.step) begin
				case (op_t'(it_q.op))
					OP_TICK: if (alive_q[iw] && asleep_q[iw] && wake_q[iw] == tnow)
						asleep_q[iw] <= 1'b0;
					OP_SCHEDULE: if (!asleep_q[p_q] && !blocked_q[p_q]
							&& {1'b0, prio_q[p_q]} < best_q)
						cur_q <= p_q;
					default: ;
				endcase
			end
			if (cmd.finish) begin
				case (op_t'(it_q.op))
					OP_SLEEP: asleep_q[cur_ix] <= 1'b1;
					OP_ADD: if (free_ok_q && tcnt_q < CW'(MAX_SLOTS)) begin
						alive_q[free_q]   <= 1'b1;
						asleep_q[free_q]  <= 1'b0;
						blocked_q[free_q] <= 1'b0;
						idc_q  <= idc_q + 16'd1;
						tcnt_q <= tcnt_q + CW'(1);
					end
					OP_EVENT: if (ecnt_q < CW'(MAX_SLOTS))
						ecnt_q <= ecnt_q + CW'(1);
					OP_KILL: if (tcnt_q != CW'(1) && kill_ok_q) begin
						alive_q[kill_q] <= 1'b0;
						if (tcnt_q != '0)
							tcnt_q <= tcnt_q - CW'(1);
					end
					OP_BLOCK: if ({29'd0, it_q.slot} < 32'(MAX_SLOTS))
						blocked_q[it_q.slot[SW-1:0]] <= it_q.blocked_flag;
					default: ;
				endcase
			end
		end
	end

	// walk state and payload tables
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			it_q      <= in_item;
			idx_q     <= '0;
			p_q       <= nxt_q[cur_ix];
			best_q    <= 9'(NO_PRIORITY);
			free_ok_q <= 1'b0;
			kill_ok_q <= 1'b0;
		end
		if (cmd.step) begin
			idx_q <= idx_q + CW'(1);
			case (op_t'(it_q.op))
				OP_TICK: if (sts.ev_fire) begin
					edue_q[iw] <= eper_q[iw] + tnow;
					fire_q     <= iw;
				end
				OP_SCHEDULE: begin
					if (!asleep_q[p_q] && !blocked_q[p_q] && {1'b0, prio_q[p_q]} < best_q)
						best_q <= {1'b0, prio_q[p_q]};
					p_q <= nxt_q[p_q];
				end
				OP_ADD: if (!free_ok_q && !alive_q[iw]) begin
					free_ok_q <= 1'b1;
					free_q    <= iw;
				end
				OP_KILL: if (!kill_ok_q && alive_q[iw] && id_q[iw] == it_q.thread_id) begin
					kill_ok_q <= 1'b1;
					kill_q    <= iw;
				end
				default: ;
			endcase
		end
		if (cmd.finish) begin
			st_q <= fin_st;
			case (op_t'(it_q.op))
				OP_SLEEP: wake_q[cur_ix] <= it_q.duration + time_q;
				OP_ADD: if (free_ok_q && tcnt_q < CW'(MAX_SLOTS)) begin
					prio_q[free_q] <= it_q.priority_req;
					id_q[free_q]   <= {idc_q, 16'(free_q)};
					if (tcnt_q == '0) begin
						nxt_q[free_q] <= free_q;
						prv_q[free_q] <= free_q;
					end else begin
						// new slot may be the killed current slot or its old successor
						if (nxt_q[cur_ix] != free_q)
							prv_q[nxt_q[cur_ix]] <= free_q;
						if (free_q != cur_ix)
							nxt_q[free_q] <= nxt_q[cur_ix];
						nxt_q[cur_ix] <= free_q;
						prv_q[free_q] <= cur_ix;
					end
				end
				OP_EVENT: if (ecnt_q < CW'(MAX_SLOTS)) begin
					eper_q[ecnt_q[SW-1:0]] <= it_q.period;
					edue_q[ecnt_q[SW-1:0]] <= it_q.period + time_q;
				end
				OP_KILL: if (tcnt_q != CW'(1) && kill_ok_q) begin
					nxt_q[prv_q[kill_q]] <= nxt_q[kill_q];
					prv_q[nxt_q[kill_q]] <= prv_q[kill_q];
				end
				default: ;
			endcase
		end
	end

	// status result contents
	always_comb begin
		st_item                  = '0;
		st_item.status           = st_q;
		st_item.thread_id_out    = cur_id;
		st_item.current_slot_out = 3'(cur_q);
		st_item.last             = 1'b1;
		case (op_t'(it_q.op))
			OP_TICK, OP_SLEEP: st_item.switch_request = 1'b1;
			OP_ADD: if (st_q == ST_OK)
				st_item.thread_id_out = id_q[free_q];
			OP_EVENT: if (st_q == ST_OK)
				st_item.event_index = 3'(ecnt_q - CW'(1));
			OP_KILL: if (st_q == ST_OK)
				st_item.switch_request = (kill_q == cur_q);
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_ev) begin
			res <= '{kind: 1'b1, status: ST_OK, event_index: 3'(fire_q),
				thread_id_out: 32'd0, current_slot_out: 3'(cur_q),
				switch_request: 1'b0, last: 1'b0};
		end else if (cmd.load_st) begin
			res <= st_item;
		end
	end

endmodule

>>> design/pts_ctrl.sv
// ----------------------------------------------------------------------------
// pts_ctrl
// Sequencer: accept, walk, emit fired events, finish, present status.
// ----------------------------------------------------------------------------
module pts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  logic          res_last,
	input  pts_pkg::sts_t sts,
	output pts_pkg::cmd_t cmd
);
	import pts_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_WALK;
				end
			end
			S_WALK: begin
				if (sts.walk_done) begin
					cmd.finish = 1'b1;
					state_d    = S_DONE;
				end else begin
					cmd.step = 1'b1;
					if (sts.ev_fire)
						state_d = S_EMIT_EV;
				end
			end
			S_EMIT_EV: begin
				cmd.load_ev = 1'b1;
				state_d     = S_OUT;
			end
			S_DONE: begin
				cmd.load_st = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready)
					state_d = res_last ? S_IDLE : S_WALK;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

>>> design/priority_thread_scheduler.sv
// ----------------------------------------------------------------------------
// priority_thread_scheduler
// Thread slot table with ring scheduling, sleep and periodic events.
// ----------------------------------------------------------------------------
// One item at a time. Tick, add thread and kill walk all MAX_SLOTS entries one
// per cycle, a tick pausing for each fired event; schedule walks thread_count
// ring steps; other ops finish at once. The time an item takes is set by the
// single shared walk unit in the datapath and by the handshake of each fired
// event and result.
module priority_thread_scheduler #(
	parameter int MAX_SLOTS = pts_pkg::MAX_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pts_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output pts_pkg::out_item_t out_data
);
	import pts_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .res_last(out_data.last),
		.sts(sts), .cmd(cmd)
	);

	pts_datapath #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .cmd(cmd), .sts(sts),
		.res(out_data)
	);

`ifndef NO_ASSERTIONS
	// no new item while a result is offered
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("accept during output");
	// a fired event result is never the last
	a_evlast: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind |-> !out_data.last) else $error("event marked last");
	// only one command kind per cycle
	a_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd)) else $error("command overlap");
`endif

endmodule

>>> tb/sv/priority_thread_scheduler_tb.sv
// ----------------------------------------------------------------------------
// priority_thread_scheduler_tb
// Drives tick, schedule, sleep, add, event, kill, block and nop items into
// the scheduler with random gaps and stalls, predicts every result from a
// shadow thread table, compares each returned item field by field in order.
// ----------------------------------------------------------------------------
module priority_thread_scheduler_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pts_pkg::*;

	localparam int NSLOT = MAX_SLOTS_DEF;

	// shadow of the scheduler table with a queue of predicted items
	class sched_scoreboard;
		bit        alive [NSLOT];
		bit        asleep [NSLOT];
		bit        blocked [NSLOT];
		bit [7:0]  prio [NSLOT];
		bit [31:0] wake [NSLOT];
		bit [2:0]  nxt [NSLOT];
		bit [2:0]  prv [NSLOT];
		bit [31:0] tid [NSLOT];
		bit [2:0]  cur;
		int        nthreads;
		bit [31:0] now;
		bit [15:0] id_ctr;
		bit [31:0] ev_period [NSLOT];
		bit [31:0] ev_due [NSLOT];
		int        nevents;
		out_item_t pending [$];
		int        errors;

		function bit [31:0] cur_id();
			return alive[cur] ? tid[cur] : 32'd0;
		endfunction

		function void push(bit kind, status_t st, bit [2:0] ev, bit [31:0] id,
				bit sw, bit lst);
			out_item_t o;
			o.kind = kind;
			o.status = st;
			o.event_index = ev;
			o.thread_id_out = id;
			o.current_slot_out = cur;
			o.switch_request = sw;
			o.last = lst;
			pending.push_back(o);
		endfunction

		// apply one accepted item and predict its results
		function void note_input(in_item_t it);
			status_t st;
			bit [2:0] ev;
			bit sw;
			int best, f, k;
			bit [2:0] p;
			st = ST_OK;
			ev = 3'd0;
			sw = 0;
			case (op_t'(it.op))
				OP_TICK: begin
					now = now + 1;
					for (int i = 0; i < nevents; i++)
						if (ev_due[i] == now) begin
							ev_due[i] = ev_period[i] + now;
							push(1'b1, ST_OK, i[2:0], 32'd0, 1'b0, 1'b0);
						end
					for (int i = 0; i < NSLOT; i++)
						if (alive[i] && asleep[i] && wake[i] == now)
							asleep[i] = 0;
					sw = 1;
				end
				OP_SCHEDULE: begin
					best = NO_PRIORITY;
					p = nxt[cur];
					for (int i = 0; i < nthreads; i++) begin
						if (!asleep[p] && !blocked[p] && prio[p] < best) begin
							cur = p;
							best = prio[p];
						end
						p = nxt[p];
					end
				end
				OP_SLEEP: begin
					wake[cur] = it.duration + now;
					asleep[cur] = 1;
					sw = 1;
				end
				OP_ADD: begin
					f = NSLOT;
					if (nthreads < NSLOT)
						for (int i = NSLOT - 1; i >= 0; i--)
							if (!alive[i])
								f = i;
					if (f >= NSLOT) begin
						st = ST_FULL;
					end else begin
						alive[f] = 1;
						asleep[f] = 0;
						blocked[f] = 0;
						prio[f] = it.priority_req;
						tid[f] = {id_ctr, 16'(f)};
						id_ctr++;
						if (nthreads == 0) begin
							nxt[f] = f;
							prv[f] = f;
						end else begin
							prv[nxt[cur]] = f;
							nxt[f] = nxt[cur];
							nxt[cur] = f;
							prv[f] = cur;
						end
						nthreads++;
						push(1'b0, ST_OK, 3'd0, tid[f], 1'b0, 1'b1);
						return;
					end
				end
				OP_EVENT: begin
					if (nevents >= NSLOT) begin
						st = ST_FULL;
					end else begin
						ev_period[nevents] = it.period;
						ev_due[nevents] = it.period + now;
						ev = nevents[2:0];
						nevents++;
					end
				end
				OP_KILL: begin
					k = NSLOT;
					if (nthreads == 1) begin
						st = ST_LAST;
					end else begin
						for (int i = NSLOT - 1; i >= 0; i--)
							if (alive[i] && tid[i] == it.thread_id)
								k = i;
						if (k >= NSLOT) begin
							st = ST_NOTFOUND;
						end else begin
							alive[k] = 0;
							nxt[prv[k]] = nxt[k];
							prv[nxt[k]] = prv[k];
							if (k == cur)
								sw = 1;
							if (nthreads > 0)
								nthreads--;
						end
					end
				end
				OP_BLOCK: blocked[it.slot] = it.blocked_flag;
				default: ;
			endcase
			push(1'b0, st, ev, cur_id(), sw, 1'b1);
		endfunction

		function void check_result(out_item_t got);
			out_item_t w;
			if (pending.size() == 0) begin
				report_mismatch("result with nothing expected", got, got);
				return;
			end
			w = pending.pop_front();
			if (got.kind != w.kind) report_mismatch("kind", got, w);
			if (got.status != w.status) report_mismatch("status", got, w);
			if (got.event_index != w.event_index) report_mismatch("event_index", got, w);
			if (got.thread_id_out != w.thread_id_out) report_mismatch("thread_id", got, w);
			if (got.current_slot_out != w.current_slot_out)
				report_mismatch("current_slot", got, w);
			if (got.switch_request != w.switch_request) report_mismatch("switch", got, w);
			if (got.last != w.last) report_mismatch("last", got, w);
		endfunction

		function void report_mismatch(string what, out_item_t got, out_item_t w);
			errors++;
			if (errors <= 40)
				$display("mismatch %s: got %h expected %h at %0t", what, got, w, $time);
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	sched_scoreboard sb;
	bit        stim_done;

	priority_thread_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// clock
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// random gap, sometimes none for a while
	function int draw_gap(bit burst);
		return burst ? 0 : $urandom_range(11, 0);
	endfunction

	// send one item after a gap, hold until accepted
	task automatic send_item(in_item_t it, int gap);
		bit acc;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		// ready comes from a register, so its value ahead of the edge decides
		do begin
			@(negedge clk);
			acc = in_ready;
			@(posedge clk);
		end while (!acc);
		sb.note_input(it);
	endtask

	function in_item_t make_item(op_t op);
		in_item_t it;
		logic [127:0] r;
		r = {$urandom, $urandom, $urandom, $urandom};
		it = r[$bits(in_item_t)-1:0];
		it.op = op;
		// short sleeps and periods so wakes and firings happen
		if ($urandom_range(3, 0) != 0) it.duration = $urandom_range(6, 0);
		if ($urandom_range(3, 0) != 0) it.period = $urandom_range(6, 0);
		// mostly kill a thread id taken from the table, live or dead
		if ($urandom_range(3, 0) != 0) it.thread_id = sb.tid[$urandom_range(NSLOT - 1, 0)];
		return it;
	endfunction

	// result side with random stalls
	initial begin
		bit burst;
		bit acc;
		int gap;
		out_item_t got;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			burst = ($urandom_range(7, 0) == 0);
			gap = burst ? 0 : $urandom_range(11, 0);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do begin
				@(negedge clk);
				acc = out_valid;
				got = out_data;
				@(posedge clk);
			end while (!acc);
			sb.check_result(got);
		end
	end

	// stimulus
	initial begin
		in_item_t it;
		bit burst;
		op_t ops [$];
		sb = new();
		in_valid = 1'b0;
		in_data = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ops on an empty table, extremes, fill and overfill
		ops = '{OP_TICK, OP_SCHEDULE, OP_SLEEP, OP_KILL, OP_BLOCK, OP_NOP, OP_EVENT};
		foreach (ops[i]) begin
			it = make_item(ops[i]);
			send_item(it, draw_gap(0));
		end
		for (int i = 0; i < 9; i++) begin
			it = make_item(OP_ADD);
			it.priority_req = (i == 0) ? 8'h00 : (i == 1) ? 8'hff : $urandom;
			send_item(it, draw_gap(0));
		end
		it = make_item(OP_EVENT);
		it.period = 32'hffff_ffff;
		send_item(it, 0);
		it = make_item(OP_EVENT);
		it.period = 0;
		send_item(it, 0);
		it = make_item(OP_KILL);
		it.thread_id = 32'hffff_ffff;
		send_item(it, 0);
		it = make_item(OP_KILL);
		it.thread_id = sb.tid[sb.cur];
		send_item(it, 0);
		it = make_item(OP_ADD);
		send_item(it, 0);
		it = make_item(OP_SLEEP);
		it.duration = 32'hffff_ffff;
		send_item(it, 0);
		it = make_item(OP_BLOCK);
		it.slot = 3'd7;
		it.blocked_flag = 1'b1;
		send_item(it, 0);
		in_valid <= 1'b0;

		// hold off until the table has answered everything
		while (sb.pending.size() != 0) @(posedge clk);

		// random mix weighted toward ticks and schedules
		for (int n = 0; n < 390; n++) begin
			int r;
			op_t op;
			r = $urandom_range(99, 0);
			op = (r < 28) ? OP_TICK : (r < 48) ? OP_SCHEDULE : (r < 58) ? OP_SLEEP :
				(r < 68) ? OP_ADD : (r < 72) ? OP_EVENT : (r < 84) ? OP_KILL :
				(r < 97) ? OP_BLOCK : OP_NOP;
			if (n % 60 == 0) burst = ~burst;
			it = make_item(op);
			send_item(it, draw_gap(burst));
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// end of run
	initial begin
		wait (stim_done);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// watchdog
	initial begin
		#40ms;
		$display("FAILURE");
		$finish;
	end

endmodule

>>> priority_thread_scheduler.f
design/pts_pkg.sv
design/pts_datapath.sv
design/pts_ctrl.sv
design/priority_thread_scheduler.sv
tb/sv/priority_thread_scheduler_tb.sv
